// ===== design/tevq_pkg.sv =====
// shared types and constants of the touch event qualifier
package tevq_pkg;

   localparam int unsigned ScanTicksDefault = 10;
   localparam int unsigned TickWidth        = 4;
   localparam int unsigned IdleWidth        = 2;
   localparam int unsigned RawWidth         = 12;
   localparam int unsigned PosXWidth        = 10;
   localparam int unsigned PosYWidth        = 9;
   localparam int unsigned CsrIndexWidth    = 1;
   localparam int unsigned CsrDataWidth     = 8;

   // configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CsrEnable  = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CsrPanelId = 1'd1;

   // event codes
   localparam logic [1:0] EvDown    = 2'd0;
   localparam logic [1:0] EvMove    = 2'd1;
   localparam logic [1:0] EvRelease = 2'd2;

   // item kinds
   localparam logic KindTick = 1'b0;
   localparam logic KindPoll = 1'b1;

   // panel handling
   localparam logic [7:0]          SmallPanelId = 8'h55;
   localparam logic [3:0]          InvalidPoint = 4'hF;
   localparam logic [RawWidth-1:0] SmallMaxX    = 12'd479;
   localparam logic [RawWidth-1:0] SmallMaxY    = 12'd271;
   localparam logic [RawWidth-1:0] LargeMaxX    = 12'd799;
   localparam logic [RawWidth-1:0] LargeMaxY    = 12'd479;
   localparam logic [IdleWidth-1:0] ReleaseScans = 2'd3;

   typedef struct packed {
      logic       kind;
      logic       touch_line;
      logic [7:0] x_high_byte;
      logic [7:0] x_low_byte;
      logic [7:0] y_high_byte;
      logic [7:0] y_low_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]           event_code;
      logic [PosXWidth-1:0] pos_x;
      logic [PosYWidth-1:0] pos_y;
   } rsp_type;

   typedef struct packed {
      logic go;
      logic emit;
   } scan_status_type;

endpackage

// ===== design/tevq_coord.sv =====
// coordinate swap and clamp for point 0
module tevq_coord (
   input  logic [tevq_pkg::RawWidth-1:0]  raw_x,
   input  logic [tevq_pkg::RawWidth-1:0]  raw_y,
   input  logic [7:0]                     panel_id,
   output logic [tevq_pkg::PosXWidth-1:0] pos_x,
   output logic [tevq_pkg::PosYWidth-1:0] pos_y
);

   logic [tevq_pkg::RawWidth-1:0] src_x;
   logic [tevq_pkg::RawWidth-1:0] src_y;
   logic [tevq_pkg::RawWidth-1:0] max_x;
   logic [tevq_pkg::RawWidth-1:0] max_y;
   logic [tevq_pkg::RawWidth-1:0] clip_x;
   logic [tevq_pkg::RawWidth-1:0] clip_y;

   always_comb begin
      if (panel_id == tevq_pkg::SmallPanelId) begin
         src_x = raw_y;
         src_y = raw_x;
         max_x = tevq_pkg::SmallMaxX;
         max_y = tevq_pkg::SmallMaxY;
      end else begin
         src_x = raw_x;
         src_y = raw_y;
         max_x = tevq_pkg::LargeMaxX;
         max_y = tevq_pkg::LargeMaxY;
      end
      clip_x = (src_x > max_x) ? max_x : src_x;
      clip_y = (src_y > max_y) ? max_y : src_y;
   end

   assign pos_x = clip_x[tevq_pkg::PosXWidth-1:0];
   assign pos_y = clip_y[tevq_pkg::PosYWidth-1:0];

endmodule

// ===== design/tevq_scan.sv =====
// scan state: tick counter, press tracking and event decision
module tevq_scan #(
   parameter int unsigned SCAN_TICKS = tevq_pkg::ScanTicksDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      item_valid,
   input  tevq_pkg::req_type         item,
   input  logic                      out_free,
   input  logic                      enable,
   input  logic [7:0]                panel_id,
   output tevq_pkg::scan_status_type status,
   output tevq_pkg::rsp_type         result
);

   localparam logic [tevq_pkg::TickWidth-1:0] ScanTicksW = tevq_pkg::TickWidth'(SCAN_TICKS);

   logic [tevq_pkg::TickWidth-1:0] tick_count_ff, tick_count_in;
   logic                           pressed_ff, pressed_in;
   logic [tevq_pkg::IdleWidth-1:0] idle_scans_ff, idle_scans_in;
   logic [tevq_pkg::PosXWidth-1:0] saved_x_ff, saved_x_in;
   logic [tevq_pkg::PosYWidth-1:0] saved_y_ff, saved_y_in;
   logic [tevq_pkg::RawWidth-1:0]  raw_x_ff, raw_x_in;
   logic [tevq_pkg::RawWidth-1:0]  raw_y_ff, raw_y_in;

   logic [tevq_pkg::IdleWidth-1:0] idle_next;
   logic [tevq_pkg::RawWidth-1:0]  new_x;
   logic [tevq_pkg::RawWidth-1:0]  new_y;
   logic [tevq_pkg::PosXWidth-1:0] pos_x;
   logic [tevq_pkg::PosYWidth-1:0] pos_y;
   logic                           period_done;
   logic                           poll_fire;
   logic                           emit;

   assign period_done = (tick_count_ff >= ScanTicksW);
   assign poll_fire   = (item.kind == tevq_pkg::KindPoll) && enable && period_done;
   assign idle_next   = idle_scans_ff + 1'b1;
   assign new_x       = {item.x_high_byte[3:0], item.x_low_byte};
   assign new_y       = {item.y_high_byte[3:0], item.y_low_byte};

   // coordinates from the raw values as they stand after this scan
   tevq_coord u_coord (
      .raw_x    (raw_x_in),
      .raw_y    (raw_y_in),
      .panel_id (panel_id),
      .pos_x    (pos_x),
      .pos_y    (pos_y)
   );

   always_comb begin
      tick_count_in = tick_count_ff;
      pressed_in    = pressed_ff;
      idle_scans_in = idle_scans_ff;
      saved_x_in    = saved_x_ff;
      saved_y_in    = saved_y_ff;
      raw_x_in      = raw_x_ff;
      raw_y_in      = raw_y_ff;
      emit          = 1'b0;
      result        = '{event_code: tevq_pkg::EvRelease, pos_x: saved_x_ff, pos_y: saved_y_ff};
      if (item.kind == tevq_pkg::KindTick) begin
         if (!period_done) begin
            tick_count_in = tick_count_ff + 1'b1;
         end
      end else if (poll_fire) begin
         tick_count_in = '0;
         if (!item.touch_line) begin
            if (pressed_ff) begin
               idle_scans_in = idle_next;
               if (idle_next == tevq_pkg::ReleaseScans) begin
                  idle_scans_in = '0;
                  pressed_in    = 1'b0;
                  emit          = 1'b1;
               end
            end
         end else begin
            idle_scans_in = '0;
            if (item.y_high_byte[7:4] != tevq_pkg::InvalidPoint) begin
               raw_x_in = new_x;
               raw_y_in = new_y;
            end
            pressed_in = 1'b1;
            saved_x_in = pos_x;
            saved_y_in = pos_y;
            emit       = 1'b1;
            result     = '{event_code: (pressed_ff ? tevq_pkg::EvMove : tevq_pkg::EvDown),
                           pos_x: pos_x, pos_y: pos_y};
         end
      end
   end

   assign status.emit = emit;
   assign status.go   = item_valid && (!emit || out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         pressed_ff    <= 1'b0;
         idle_scans_ff <= '0;
         saved_x_ff    <= '0;
         saved_y_ff    <= '0;
         raw_x_ff      <= '0;
         raw_y_ff      <= '0;
      end else if (status.go) begin
         tick_count_ff <= tick_count_in;
         pressed_ff    <= pressed_in;
         idle_scans_ff <= idle_scans_in;
         saved_x_ff    <= saved_x_in;
         saved_y_ff    <= saved_y_in;
         raw_x_ff      <= raw_x_in;
         raw_y_ff      <= raw_y_in;
      end
   end

endmodule

// ===== design/touch_event_qualifier.sv =====
// top level of the touch event qualifier
//
// requests come in on req_valid / req_stall / req_data: each one is a one
// millisecond tick or a scan poll carrying the touch line level and the raw
// point 0 bytes. a poll that finds the block enabled and the scan period
// elapsed yields at most one event (down, move or release) on rsp_valid /
// rsp_stall / rsp_data. ticks and early or disabled polls yield nothing.
// csr_valid / csr_ready / csr_index / csr_wdata write enable and panel_id;
// csr_ready is always high, writes are meant to land while the block is idle.
// the request is held in the input register while the scan logic works on it;
// once it moves on, the state is updated and its event, if any, is loaded
// into the output register, which drives rsp.
// throughput: one request per cycle unless req_stall is high, set by the
// single register stage holding the request during state update and swap/clamp.
// a request that yields no event moves on even while an event waits under
// rsp_stall; a request that yields one waits in the input register until the
// output register frees up, and req_stall is raised meanwhile.
// reset (synchronous, active high) clears the counters, press state, saved
// and raw coordinates, both configuration registers and both valid flags.
module touch_event_qualifier #(
   parameter int unsigned SCAN_TICKS = tevq_pkg::ScanTicksDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  tevq_pkg::req_type                     req_data,
   // event channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output tevq_pkg::rsp_type                     rsp_data,
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tevq_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [tevq_pkg::CsrDataWidth-1:0]     csr_wdata
);

   // input register
   logic              req_valid_ff, req_valid_in;
   tevq_pkg::req_type req_data_ff;
   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   tevq_pkg::rsp_type rsp_data_ff;
   // configuration
   logic              enable_ff, enable_in;
   logic [7:0]        panel_id_ff, panel_id_in;

   tevq_pkg::scan_status_type status;
   tevq_pkg::rsp_type         result;
   logic                      req_take;
   logic                      out_free;
   logic                      csr_take;

   // the output slot can take a new event if empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = req_valid_ff && !status.go;
   assign req_take  = req_valid && !req_stall;

   tevq_scan #(
      .SCAN_TICKS (SCAN_TICKS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_valid_ff),
      .item       (req_data_ff),
      .out_free   (out_free),
      .enable     (enable_ff),
      .panel_id   (panel_id_ff),
      .status     (status),
      .result     (result)
   );

   // input stage holds the request until the scan logic lets it go
   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (status.go) begin
         req_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_data_ff <= req_data;
      end
   end

   // output register, refilled as soon as the current event is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (status.go && status.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (status.go && status.emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // register writes, always accepted
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   always_comb begin
      enable_in   = enable_ff;
      panel_id_in = panel_id_ff;
      if (csr_take) begin
         unique case (csr_index)
            tevq_pkg::CsrEnable:  enable_in   = csr_wdata[0];
            tevq_pkg::CsrPanelId: panel_id_in = csr_wdata;
            default: begin
               enable_in   = enable_ff;
               panel_id_in = panel_id_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         panel_id_ff <= '0;
      end else begin
         enable_ff   <= enable_in;
         panel_id_ff <= panel_id_in;
      end
   end

endmodule
